>>> rtl/esc_pkg.sv
// Shared types, constants and helpers for the environmental sensor compensation core.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
package esc_pkg;

  localparam int CfgWidth = 64;
  localparam int CfgIdxWidth = 3;
  localparam int DivSteps = 32;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_TEMP     = 3'd0,
    CFG_PRESS_LO = 3'd1,
    CFG_PRESS_HI = 3'd2,
    CFG_MIXED    = 3'd3,
    CFG_HUM      = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;
    logic [15:0] raw_humidity;
  } in_t;

  typedef struct packed {
    logic signed [26:0] temperature_centi;
    logic [31:0]        pressure_pa;
    logic               pressure_valid;
    logic [16:0]        humidity_q10;
  } out_t;

  // calibration coefficients, decoded from the register words
  typedef struct packed {
    logic [15:0]        t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic [15:0]        p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
    logic [7:0]         h1;
    logic signed [15:0] h2;
    logic [7:0]         h3;
    logic signed [11:0] h4;
    logic signed [11:0] h5;
    logic signed [7:0]  h6;
  } cal_t;

  // values that ride along with the pressure divide
  typedef struct packed {
    logic signed [26:0] temp;
    logic [16:0]        hum;
    logic               pvalid;
    logic               post_dbl;
  } side_t;

  typedef struct packed {
    logic [31:0] dividend;
    logic [31:0] divisor;
    side_t       side;
  } div_in_t;

  typedef struct packed {
    logic [31:0] quot;
    side_t       side;
  } div_out_t;

  function automatic logic signed [31:0] sx16(logic signed [15:0] v);
    return $signed({{16{v[15]}}, v});
  endfunction

  function automatic logic signed [31:0] sx12(logic signed [11:0] v);
    return $signed({{20{v[11]}}, v});
  endfunction

  function automatic logic signed [31:0] sx8(logic signed [7:0] v);
    return $signed({{24{v[7]}}, v});
  endfunction

  function automatic logic signed [31:0] zx16(logic [15:0] v);
    return $signed({16'd0, v});
  endfunction

  function automatic logic signed [31:0] zx8(logic [7:0] v);
    return $signed({24'd0, v});
  endfunction

endpackage

>>> rtl/esc_cfg.sv
// Calibration register file: five write-only words, decoded into coefficients.
// Depends on esc_pkg.
`timescale 1ns / 1ps
module esc_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [esc_pkg::CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [esc_pkg::CfgWidth-1:0]    cfg_wdata_i,
  output esc_pkg::cal_t                   cal_o
);
  import esc_pkg::*;

  logic [47:0] temp_q;
  logic [63:0] press_lo_q;
  logic [63:0] press_hi_q;
  logic [47:0] mixed_q;
  logic [31:0] hum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_q     <= '0;
      press_lo_q <= '0;
      press_hi_q <= '0;
      mixed_q    <= '0;
      hum_q      <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TEMP:     temp_q     <= cfg_wdata_i[47:0];
        CFG_PRESS_LO: press_lo_q <= cfg_wdata_i;
        CFG_PRESS_HI: press_hi_q <= cfg_wdata_i;
        CFG_MIXED:    mixed_q    <= cfg_wdata_i[47:0];
        CFG_HUM:      hum_q      <= cfg_wdata_i[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cal_o.t1 = temp_q[15:0];
    cal_o.t2 = $signed(temp_q[31:16]);
    cal_o.t3 = $signed(temp_q[47:32]);
    cal_o.p1 = press_lo_q[15:0];
    cal_o.p2 = $signed(press_lo_q[31:16]);
    cal_o.p3 = $signed(press_lo_q[47:32]);
    cal_o.p4 = $signed(press_lo_q[63:48]);
    cal_o.p5 = $signed(press_hi_q[15:0]);
    cal_o.p6 = $signed(press_hi_q[31:16]);
    cal_o.p7 = $signed(press_hi_q[47:32]);
    cal_o.p8 = $signed(press_hi_q[63:48]);
    cal_o.p9 = $signed(mixed_q[15:0]);
    cal_o.h1 = mixed_q[23:16];
    cal_o.h2 = $signed(mixed_q[39:24]);
    cal_o.h3 = mixed_q[47:40];
    cal_o.h4 = $signed(hum_q[11:0]);
    cal_o.h5 = $signed(hum_q[23:12]);
    cal_o.h6 = $signed(hum_q[31:24]);
  end

endmodule

>>> rtl/esc_front.sv
// Front pipeline: fine temperature, humidity and the pressure numerator/divisor,
// fifteen register stages, at most one multiply deep each. Depends on esc_pkg.
`timescale 1ns / 1ps
module esc_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  esc_pkg::in_t     data_i,
  input  esc_pkg::cal_t    cal_i,
  output logic             valid_o,
  output esc_pkg::div_in_t data_o
);
  import esc_pkg::*;

  logic [14:0] vld_q;

  // stage registers, numbered by stage
  logic signed [31:0] s1_x_q, s1_d_q;
  logic [19:0]        s1_p_q;
  logic [15:0]        s1_h_q;
  logic signed [31:0] s2_m1_q, s2_dd_q;
  logic [19:0]        s2_p_q;
  logic [15:0]        s2_h_q;
  logic signed [31:0] s3_a_q, s3_e_q;
  logic [19:0]        s3_p_q;
  logic [15:0]        s3_h_q;
  logic signed [31:0] s4_tf_q;
  logic [19:0]        s4_p_q;
  logic [15:0]        s4_h_q;
  logic signed [26:0] s5_t_q;
  logic signed [31:0] s5_pa_q, s5_v_q;
  logic [19:0]        s5_p_q;
  logic [15:0]        s5_h_q;
  logic signed [26:0] s6_t_q;
  logic signed [31:0] s6_pq_q, s6_pm5_q, s6_pm2_q, s6_hx_q, s6_hm6_q, s6_hm3_q;
  logic [19:0]        s6_p_q;
  logic signed [26:0] s7_t_q;
  logic signed [31:0] s7_pb1_q, s7_pc_q, s7_pm5_q, s7_pm2_q, s7_ha_q, s7_hb_q, s7_hd_q;
  logic [19:0]        s7_p_q;
  logic signed [26:0] s8_t_q;
  logic signed [31:0] s8_pb_q, s8_pa_q, s8_hbd_q, s8_ha_q;
  logic [19:0]        s8_p_q;
  logic signed [26:0] s9_t_q;
  logic signed [31:0] s9_dv_q, s9_hb2_q, s9_ha_q;
  logic [31:0]        s9_pn_q;
  logic signed [26:0] s10_t_q;
  logic signed [31:0] s10_dv_q, s10_hbh_q, s10_ha_q;
  logic [31:0]        s10_pn3_q;
  logic signed [26:0] s11_t_q;
  logic signed [31:0] s11_dv_q, s11_hb3_q, s11_ha_q;
  logic [31:0]        s11_pn3_q;
  logic signed [26:0] s12_t_q;
  logic signed [31:0] s12_dv_q, s12_hv_q;
  logic [31:0]        s12_pn3_q;
  logic signed [26:0] s13_t_q;
  logic signed [31:0] s13_dv_q, s13_hv_q, s13_hq_q;
  logic [31:0]        s13_pn3_q;
  logic signed [26:0] s14_t_q;
  logic signed [31:0] s14_dv_q, s14_hv_q, s14_hm_q;
  logic [31:0]        s14_pn3_q;
  div_in_t            s15_q;

  // combinational terms of each stage
  logic signed [31:0] c3_e_sh, c5_t, c5_ts, c6_pa4, c6_hx, c7_q11, c7_q13;
  logic signed [31:0] c8_pb, c8_pa, c9_dv, c9_prod, c12_hq_in, c14_q7;
  logic signed [31:0] c15_hv, c15_cl;
  logic [31:0]        c9_pn;

  always_comb begin
    c3_e_sh   = s2_dd_q >>> 12;
    c5_t      = (s4_tf_q <<< 2) + s4_tf_q + 32'sd128;
    c5_ts     = c5_t >>> 8;
    c6_pa4    = s5_pa_q >>> 2;
    c6_hx     = $signed({2'b00, s5_h_q, 14'd0}) - $signed({cal_i.h4, 20'd0})
              - (s5_v_q * sx12(cal_i.h5));
    c7_q11    = s6_pq_q >>> 11;
    c7_q13    = s6_pq_q >>> 13;
    c8_pb     = ((s7_pb1_q + s7_pm5_q) >>> 2) + $signed({cal_i.p4, 16'd0});
    c8_pa     = ((s7_pc_q >>> 3) + (s7_pm2_q >>> 1)) >>> 18;
    c9_prod   = (32'sd32768 + s8_pa_q) * zx16(cal_i.p1);
    c9_dv     = c9_prod >>> 15;
    c9_pn     = 32'd1048576 - {12'd0, s8_p_q} - $unsigned(s8_pb_q >>> 12);
    c12_hq_in = s12_hv_q >>> 15;
    c14_q7    = s13_hq_q >>> 7;
    c15_hv    = s14_hv_q - (s14_hm_q >>> 4);
    if (c15_hv < 32'sd0) begin
      c15_cl = 32'sd0;
    end else if (c15_hv > 32'sd419430400) begin
      c15_cl = 32'sd419430400;
    end else begin
      c15_cl = c15_hv;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[13:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // fine temperature
      s1_x_q  <= $signed({15'd0, data_i.raw_temperature[19:3]})
               - $signed({15'd0, cal_i.t1, 1'b0});
      s1_d_q  <= $signed({16'd0, data_i.raw_temperature[19:4]}) - zx16(cal_i.t1);
      s1_p_q  <= data_i.raw_pressure;
      s1_h_q  <= data_i.raw_humidity;
      s2_m1_q <= s1_x_q * sx16(cal_i.t2);
      s2_dd_q <= s1_d_q * s1_d_q;
      s2_p_q  <= s1_p_q;
      s2_h_q  <= s1_h_q;
      s3_a_q  <= s2_m1_q >>> 11;
      s3_e_q  <= c3_e_sh * sx16(cal_i.t3);
      s3_p_q  <= s2_p_q;
      s3_h_q  <= s2_h_q;
      s4_tf_q <= s3_a_q + (s3_e_q >>> 14);
      s4_p_q  <= s3_p_q;
      s4_h_q  <= s3_h_q;
      // temperature output and the offsets of the other two paths
      s5_t_q  <= c5_ts[26:0];
      s5_pa_q <= (s4_tf_q >>> 1) - 32'sd64000;
      s5_v_q  <= s4_tf_q - 32'sd76800;
      s5_p_q  <= s4_p_q;
      s5_h_q  <= s4_h_q;
      s6_t_q   <= s5_t_q;
      s6_pq_q  <= c6_pa4 * c6_pa4;
      s6_pm5_q <= s5_pa_q * sx16(cal_i.p5);
      s6_pm2_q <= s5_pa_q * sx16(cal_i.p2);
      s6_hx_q  <= c6_hx;
      s6_hm6_q <= s5_v_q * sx8(cal_i.h6);
      s6_hm3_q <= s5_v_q * zx8(cal_i.h3);
      s6_p_q   <= s5_p_q;
      s7_t_q   <= s6_t_q;
      s7_pb1_q <= c7_q11 * sx16(cal_i.p6);
      s7_pc_q  <= c7_q13 * sx16(cal_i.p3);
      s7_pm5_q <= s6_pm5_q <<< 1;
      s7_pm2_q <= s6_pm2_q;
      s7_ha_q  <= (s6_hx_q + 32'sd16384) >>> 15;
      s7_hb_q  <= s6_hm6_q >>> 10;
      s7_hd_q  <= (s6_hm3_q >>> 11) + 32'sd32768;
      s7_p_q   <= s6_p_q;
      s8_t_q   <= s7_t_q;
      s8_pb_q  <= c8_pb;
      s8_pa_q  <= c8_pa;
      s8_hbd_q <= s7_hb_q * s7_hd_q;
      s8_ha_q  <= s7_ha_q;
      s8_p_q   <= s7_p_q;
      s9_t_q   <= s8_t_q;
      s9_dv_q  <= c9_dv;
      s9_pn_q  <= c9_pn;
      s9_hb2_q <= (s8_hbd_q >>> 10) + 32'sd2097152;
      s9_ha_q  <= s8_ha_q;
      s10_t_q   <= s9_t_q;
      s10_dv_q  <= s9_dv_q;
      s10_pn3_q <= s9_pn_q * 32'd3125;
      s10_hbh_q <= s9_hb2_q * sx16(cal_i.h2);
      s10_ha_q  <= s9_ha_q;
      s11_t_q   <= s10_t_q;
      s11_dv_q  <= s10_dv_q;
      s11_pn3_q <= s10_pn3_q;
      s11_hb3_q <= (s10_hbh_q + 32'sd8192) >>> 14;
      s11_ha_q  <= s10_ha_q;
      s12_t_q   <= s11_t_q;
      s12_dv_q  <= s11_dv_q;
      s12_pn3_q <= s11_pn3_q;
      s12_hv_q  <= s11_ha_q * s11_hb3_q;
      s13_t_q   <= s12_t_q;
      s13_dv_q  <= s12_dv_q;
      s13_pn3_q <= s12_pn3_q;
      s13_hv_q  <= s12_hv_q;
      s13_hq_q  <= c12_hq_in * c12_hq_in;
      s14_t_q   <= s13_t_q;
      s14_dv_q  <= s13_dv_q;
      s14_pn3_q <= s13_pn3_q;
      s14_hv_q  <= s13_hv_q;
      s14_hm_q  <= c14_q7 * zx8(cal_i.h1);
      // divide setup: large numerators are divided first and doubled after
      s15_q.divisor       <= $unsigned(s14_dv_q);
      s15_q.dividend      <= s14_pn3_q[31] ? s14_pn3_q : {s14_pn3_q[30:0], 1'b0};
      s15_q.side.post_dbl <= s14_pn3_q[31];
      s15_q.side.pvalid   <= (s14_dv_q != 32'sd0);
      s15_q.side.temp     <= s14_t_q;
      s15_q.side.hum      <= c15_cl[28:12];
    end
  end

  assign valid_o = vld_q[14];
  assign data_o  = s15_q;

endmodule

>>> rtl/esc_div.sv
// Pipelined unsigned 32/32 restoring divider, one quotient bit per stage,
// with side data carried alongside. Depends on esc_pkg.
`timescale 1ns / 1ps
module esc_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  esc_pkg::div_in_t  data_i,
  output logic              valid_o,
  output esc_pkg::div_out_t data_o
);
  import esc_pkg::*;

  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] dq;   // dividend bits shift out, quotient bits shift in
    logic [31:0] dv;
    side_t       side;
  } div_stage_t;

  div_stage_t           st_q [DivSteps];
  logic [DivSteps-1:0]  vld_q;
  div_stage_t           init;

  always_comb begin
    init.rem  = '0;
    init.dq   = data_i.dividend;
    init.dv   = data_i.divisor;
    init.side = data_i.side;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[DivSteps-2:0], valid_i};
    end
  end

  for (genvar k = 0; k < DivSteps; k++) begin : g_step
    div_stage_t  prev;
    div_stage_t  nxt;
    logic [32:0] trial;
    logic [32:0] diff;
    logic        ge;

    if (k == 0) begin : g_first
      assign prev = init;
    end else begin : g_rest
      assign prev = st_q[k-1];
    end

    always_comb begin
      trial    = {prev.rem, prev.dq[31]};
      diff     = trial - {1'b0, prev.dv};
      ge       = (trial >= {1'b0, prev.dv});
      nxt.rem  = ge ? diff[31:0] : trial[31:0];
      nxt.dq   = {prev.dq[30:0], ge};
      nxt.dv   = prev.dv;
      nxt.side = prev.side;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[k] <= nxt;
      end
    end
  end

  assign valid_o     = vld_q[DivSteps-1];
  assign data_o.quot = st_q[DivSteps-1].dq;
  assign data_o.side = st_q[DivSteps-1].side;

endmodule

>>> rtl/esc_post.sv
// Pressure correction after the divide (P7..P9 terms), three stages; the last
// stage is the output register. Depends on esc_pkg.
`timescale 1ns / 1ps
module esc_post (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  esc_pkg::div_out_t data_i,
  input  esc_pkg::cal_t     cal_i,
  output logic              valid_o,
  output esc_pkg::out_t     data_o
);
  import esc_pkg::*;

  logic [2:0]         vld_q;
  logic [31:0]        p1_p_q, p1_s_q, p2_p_q;
  logic signed [31:0] p1_c2m_q, p2_c1_q, p2_c2_q;
  side_t              p1_side_q, p2_side_q;
  out_t               out_q;

  logic [31:0]        c1_p;
  logic signed [31:0] c2_prod, c3_corr;

  always_comb begin
    c1_p    = data_i.side.post_dbl ? {data_i.quot[30:0], 1'b0} : data_i.quot;
    c2_prod = $signed({13'd0, p1_s_q[31:13]}) * sx16(cal_i.p9);
    c3_corr = (p2_c1_q + p2_c2_q + sx16(cal_i.p7)) >>> 4;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_p_q    <= c1_p;
      p1_s_q    <= {3'd0, c1_p[31:3]} * {3'd0, c1_p[31:3]};
      p1_c2m_q  <= $signed({2'd0, c1_p[31:2]}) * sx16(cal_i.p8);
      p1_side_q <= data_i.side;
      p2_p_q    <= p1_p_q;
      p2_c1_q   <= c2_prod >>> 12;
      p2_c2_q   <= p1_c2m_q >>> 13;
      p2_side_q <= p1_side_q;
      out_q.temperature_centi <= p2_side_q.temp;
      out_q.humidity_q10      <= p2_side_q.hum;
      out_q.pressure_valid    <= p2_side_q.pvalid;
      out_q.pressure_pa       <= p2_side_q.pvalid ? (p2_p_q + $unsigned(c3_corr)) : '0;
    end
  end

  assign valid_o = vld_q[2];
  assign data_o  = out_q;

endmodule

>>> rtl/env_sensor_compensation_core.sv
// Top level of the environmental sensor compensation core.
// Depends on esc_pkg, esc_cfg, esc_front, esc_div and esc_post.
`timescale 1ns / 1ps
// Accepts one raw temperature/pressure/humidity sample per clock and returns
// one compensated result per sample, in order, through 15 front stages (fine
// temperature, humidity, pressure numerator and divisor), 32 stages of the
// bit-per-stage pressure divider and 3 correction stages ending in the
// output register. Throughput is one sample per cycle unless a result waits
// on out_stall_i; then the whole pipeline holds and in_stall_o is raised.
// Calibration words must be written through the cfg port while the pipeline
// is empty, unchecked by the block; writes to unused indexes are dropped.
module env_sensor_compensation_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  esc_pkg::in_t                    in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output esc_pkg::out_t                   out_data_o,
  input  logic                            cfg_we_i,
  input  logic [esc_pkg::CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [esc_pkg::CfgWidth-1:0]    cfg_wdata_i
);
  import esc_pkg::*;

  cal_t     cal;
  logic     en;
  logic     front_vld, div_vld;
  div_in_t  front_data;
  div_out_t div_data;

  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  esc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cal_o       (cal)
  );

  esc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .cal_i   (cal),
    .valid_o (front_vld),
    .data_o  (front_data)
  );

  esc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (front_vld),
    .data_i  (front_data),
    .valid_o (div_vld),
    .data_o  (div_data)
  );

  esc_post u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (div_vld),
    .data_i  (div_data),
    .cal_i   (cal),
    .valid_o (out_valid_o),
    .data_o  (out_data_o)
  );

`ifndef SYNTHESIS
  a_zero_div_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.pressure_valid |-> out_data_o.pressure_pa == '0)
    else $error("pressure nonzero with zero divisor");

  a_hum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.humidity_q10 <= 17'd102400)
    else $error("humidity above 100 percent");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result held");
`endif

endmodule

>>> verif/tb_top.sv
// Testbench for env_sensor_compensation_core: random and directed raw samples
// against an in-bench integer compensation predictor. Depends on esc_pkg and the RTL.
`timescale 1ns / 1ps
module tb_top;
  import esc_pkg::*;

  // wrap to signed 32 bits
  function automatic longint w32(longint x);
    return longint'(int'(x[31:0]));
  endfunction

  function automatic longint asr(longint x, int n);
    return x >>> n;
  endfunction

  function automatic longint sfld(logic [63:0] w, int lo, int bits);
    longint v;
    v = longint'((w >> lo) & ((64'd1 << bits) - 1));
    if (v[bits-1]) v = v - (longint'(1) << bits);
    return v;
  endfunction

  function automatic longint ufld(logic [63:0] w, int lo, int bits);
    return longint'((w >> lo) & ((64'd1 << bits) - 1));
  endfunction

  class comp_scoreboard;
    logic [63:0] cal [5];
    out_t pending [$];
    int errors;

    function void write_cal(cfg_idx_e idx, logic [63:0] val);
      case (idx)
        CFG_TEMP:     cal[0] = val & 64'hFFFF_FFFF_FFFF;
        CFG_PRESS_LO: cal[1] = val;
        CFG_PRESS_HI: cal[2] = val;
        CFG_MIXED:    cal[3] = val & 64'hFFFF_FFFF_FFFF;
        CFG_HUM:      cal[4] = val & 64'hFFFF_FFFF;
        default: ;
      endcase
    endfunction

    function out_t compensate(in_t s);
      out_t r;
      longint t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
      longint h1, h2, h3, h4, h5, h6, at, ah, a, b, d, tf, v, q, c1, c2, corr;
      logic [31:0] p, dv;
      logic [63:0] sq;
      t1 = ufld(cal[0], 0, 16); t2 = sfld(cal[0], 16, 16); t3 = sfld(cal[0], 32, 16);
      p1 = ufld(cal[1], 0, 16); p2 = sfld(cal[1], 16, 16);
      p3 = sfld(cal[1], 32, 16); p4 = sfld(cal[1], 48, 16);
      p5 = sfld(cal[2], 0, 16); p6 = sfld(cal[2], 16, 16);
      p7 = sfld(cal[2], 32, 16); p8 = sfld(cal[2], 48, 16);
      p9 = sfld(cal[3], 0, 16); h1 = ufld(cal[3], 16, 8);
      h2 = sfld(cal[3], 24, 16); h3 = ufld(cal[3], 40, 8);
      h4 = sfld(cal[4], 0, 12); h5 = sfld(cal[4], 12, 12); h6 = sfld(cal[4], 24, 8);
      at = longint'(s.raw_temperature);
      ah = longint'(s.raw_humidity);

      a = asr(w32(w32((at >> 3) - t1 * 2) * t2), 11);
      d = (at >> 4) - t1;
      b = asr(w32(asr(w32(d * d), 12) * t3), 14);
      tf = w32(a + b);
      r.temperature_centi = 27'(asr(w32(w32(tf * 5) + 128), 8));

      a = w32(asr(tf, 1) - 64000);
      q = w32(asr(a, 2) * asr(a, 2));
      b = w32(asr(q, 11) * p6);
      b = w32(b + w32(w32(a * p5) * 2));
      b = w32(asr(b, 2) + w32(p4 * 65536));
      a = asr(w32(asr(w32(p3 * asr(q, 13)), 3) + asr(w32(p2 * a), 1)), 18);
      a = asr(w32(w32(32768 + a) * p1), 15);
      r.pressure_valid = (a != 0);
      if (a == 0) begin
        p = '0;
      end else begin
        dv = a[31:0];
        p = 32'(longint'(1048576 - longint'(s.raw_pressure)) - asr(b, 12));
        p = p * 32'd3125;
        if (p < 32'h8000_0000) p = {p[30:0], 1'b0} / dv;
        else p = (p / dv) << 1;
        sq = (64'(p >> 3) * 64'(p >> 3)) & 64'hFFFF_FFFF;
        c1 = asr(w32(p9 * longint'(sq >> 13)), 12);
        c2 = asr(w32(longint'(p >> 2) * p8), 13);
        corr = asr(w32(w32(c1 + c2) + p7), 4);
        p = p + corr[31:0];
      end
      r.pressure_pa = p;

      v = w32(tf - 76800);
      a = w32(w32(w32(ah * 16384) - w32(h4 * 1048576)) - w32(h5 * v));
      a = asr(w32(a + 16384), 15);
      b = asr(w32(v * h6), 10);
      d = w32(asr(w32(v * h3), 11) + 32768);
      b = w32(asr(w32(b * d), 10) + 2097152);
      b = asr(w32(w32(b * h2) + 8192), 14);
      v = w32(a * b);
      q = w32(asr(v, 15) * asr(v, 15));
      v = w32(v - asr(w32(asr(q, 7) * h1), 4));
      if (v < 0) v = 0;
      if (v > 419430400) v = 419430400;
      r.humidity_q10 = 17'(v >> 12);
      return r;
    endfunction

    function void note_sample(in_t s);
      pending.push_back(compensate(s));
    endfunction

    function void check_result(out_t got);
      out_t exp_r;
      if (pending.size() == 0) begin
        $error("result with no sample outstanding");
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.temperature_centi !== exp_r.temperature_centi) begin
        $error("temperature_centi exp %0d got %0d", exp_r.temperature_centi,
               got.temperature_centi);
        errors++;
      end
      if (got.pressure_pa !== exp_r.pressure_pa) begin
        $error("pressure_pa exp %0d got %0d", exp_r.pressure_pa, got.pressure_pa);
        errors++;
      end
      if (got.pressure_valid !== exp_r.pressure_valid) begin
        $error("pressure_valid exp %0d got %0d", exp_r.pressure_valid,
               got.pressure_valid);
        errors++;
      end
      if (got.humidity_q10 !== exp_r.humidity_q10) begin
        $error("humidity_q10 exp %0d got %0d", exp_r.humidity_q10, got.humidity_q10);
        errors++;
      end
    endfunction
  endclass

  localparam int Latency = 50;
  localparam longint CycleLimit = 400_000;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall, cfg_we;
  in_t in_data;
  out_t out_data;
  logic [CfgIdxWidth-1:0] cfg_idx;
  logic [CfgWidth-1:0] cfg_wdata;
  comp_scoreboard sb;
  longint cycles;

  env_sensor_compensation_core u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    sb = new();
    for (int i = 0; i < 5; i++) sb.cal[i] = '0;
    sb.errors = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("env_sensor_compensation_core verification failed");
      $finish;
    end
  end

  // result side: sample before the edge-driven updates land
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // receiver stall pattern: random wait before each transfer
  initial begin
    int w;
    out_stall = 1'b1;
    @(posedge rst_n);
    forever begin
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      if (w > 0) begin
        out_stall <= 1'b1;
        repeat (w) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic write_cal(cfg_idx_e idx, logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    sb.write_cal(idx, val);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_sample(in_t s, bit burst);
    int w;
    w = burst ? 0 : $urandom_range(0, 10);
    if (w > 0) begin
      in_valid <= 1'b0;
      repeat (w) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_sample(s);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (Latency + 5) @(posedge clk);
  endtask

  function automatic in_t rand_sample();
    in_t s;
    s.raw_temperature = 20'($urandom);
    s.raw_pressure = 20'($urandom);
    s.raw_humidity = 16'($urandom);
    return s;
  endfunction

  // typical-device calibration with an optional random jitter on some coefficients
  task automatic load_typical_cal(bit jitter);
    logic [15:0] j;
    j = jitter ? 16'($urandom_range(0, 63)) : 16'd0;
    write_cal(CFG_TEMP, {16'(50), 16'(26435 + j), 16'(27504 - j)});
    write_cal(CFG_PRESS_LO, {16'(2855), 16'(-16'sd2592 + j), 16'(-16'sd10685), 16'(36477 + j)});
    write_cal(CFG_PRESS_HI, {16'(15500), 16'(-16'sd14600), 16'(-16'sd7), 16'(140 + j)});
    write_cal(CFG_MIXED, {8'(30), 16'(360 + j), 8'(75), 16'(6000)});
    write_cal(CFG_HUM, {8'(30), 12'(0), 12'(320 + j)});
  endtask

  initial begin
    in_t s;
    bit burst;
    cycles = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset calibration: zero divisor everywhere
    send_sample('0, 0);
    send_sample('1, 1);
    drain();

    load_typical_cal(0);
    s = '0; send_sample(s, 0);
    s = '1; send_sample(s, 1);
    s.raw_temperature = 20'h80000; s.raw_pressure = 20'h60000; s.raw_humidity = 16'h6000;
    send_sample(s, 1);
    s.raw_temperature = 20'h7FFFF; s.raw_pressure = 20'h0; s.raw_humidity = 16'hFFFF;
    send_sample(s, 0);
    s.raw_temperature = 20'h0; s.raw_pressure = 20'hFFFFF; s.raw_humidity = 16'h0;
    send_sample(s, 0);
    drain();

    // all-ones calibration: every field all ones (-1 where signed)
    write_cal(CFG_TEMP, '1);
    write_cal(CFG_PRESS_LO, '1);
    write_cal(CFG_PRESS_HI, '1);
    write_cal(CFG_MIXED, '1);
    write_cal(CFG_HUM, '1);
    for (int i = 0; i < 6; i++) send_sample(rand_sample(), i[0]);
    drain();

    // most negative and most positive signed slices
    write_cal(CFG_TEMP, {16'h8000, 16'h7FFF, 16'hFFFF});
    write_cal(CFG_PRESS_LO, {16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF});
    write_cal(CFG_PRESS_HI, {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF});
    write_cal(CFG_MIXED, {8'hFF, 16'h8000, 8'hFF, 16'h7FFF});
    write_cal(CFG_HUM, {8'h80, 12'h7FF, 12'h800});
    for (int i = 0; i < 6; i++) send_sample(rand_sample(), 0);
    drain();

    // random phases: mostly realistic calibration, some fully random words
    for (int ph = 0; ph < 7; ph++) begin
      if (ph % 3 == 2) begin
        write_cal(CFG_TEMP, {$urandom, $urandom});
        write_cal(CFG_PRESS_LO, {$urandom, $urandom});
        write_cal(CFG_PRESS_HI, {$urandom, $urandom});
        write_cal(CFG_MIXED, {$urandom, $urandom});
        write_cal(CFG_HUM, {$urandom, $urandom});
      end else begin
        load_typical_cal(1);
      end
      for (int i = 0; i < 100; i++) begin
        burst = (i >= 40 && i < 60);
        s = rand_sample();
        // bias toward the normal operating range
        if ($urandom_range(0, 3) != 0) begin
          s.raw_temperature = 20'($urandom_range(400000, 600000));
          s.raw_pressure = 20'($urandom_range(250000, 450000));
        end
        send_sample(s, burst);
      end
      drain();
    end

    if (sb.errors == 0) begin
      $display("env_sensor_compensation_core verification clean");
    end else begin
      $display("env_sensor_compensation_core verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/esc_pkg.sv
rtl/esc_cfg.sv
rtl/esc_front.sv
rtl/esc_div.sv
rtl/esc_post.sv
rtl/env_sensor_compensation_core.sv
verif/tb_top.sv
